// ===== rtl/core/decimal_operator_lexer_defines.svh =====
// ----------------------------------------------------------------------------
// decimal_operator_lexer_defines
// Assertion macros shared by the lexer RTL. Each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_OPERATOR_LEXER_DEFINES_SVH
`define DECIMAL_OPERATOR_LEXER_DEFINES_SVH

// Same-cycle check.
`define DOL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define DOL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DOL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/dol_pkg.sv =====
// ----------------------------------------------------------------------------
// dol_pkg
// Types and constants of the decimal integer and operator lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dol_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 31;

  localparam logic [VALUE_W-1:0] VALUE_MAX       = {VALUE_W{1'b1}};
  localparam logic [CHAR_W-1:0]  STMT_END_RESET  = 8'd59;

  typedef enum logic [1:0] {
    KIND_INVALID  = 2'd0,
    KIND_INTEGER  = 2'd1,
    KIND_OPERATOR = 2'd2,
    KIND_EOS      = 2'd3
  } token_kind_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_input;
  } in_t;

  typedef struct packed {
    token_kind_t        token_kind;
    logic [VALUE_W-1:0] integer_value;
    logic [CHAR_W-1:0]  operator_char;
    logic               last_result;
  } out_t;

  // Tokens caused by the item at the head of the pipe.
  typedef struct packed {
    logic [1:0] n;
    out_t       first;
    out_t       second;
  } token_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/decimal_operator_lexer.sv =====
// ----------------------------------------------------------------------------
// decimal_operator_lexer
// Character-stream lexer: digit runs become saturated integers; whitespace is
// dropped; punctuation gives operator/end-of-statement tokens, others INVALID.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_data): one character, or an end-of-input
//     marker, per transaction.
//   out channel (out_valid/out_ready/out_data): one token per transaction;
//     last_result marks the final token caused by an input character.
//   cfg_wr_en/cfg_wr_data: write the end-of-statement character while idle.
// Path: the tokens of a character pass through the input register and the
//   two-entry result register; a second token follows the first.
// Throughput: one character per cycle while out_ready stays high. A character
//   that closes an integer and gives its own token queues two tokens; digits,
//   which give none, always come before the next such character, so the
//   two-entry result register drains in time and the input never waits.
// Reset (rst, synchronous): clears the digit run and both registers' valid
//   state; the end-of-statement character returns to ';'.
// Output stall: the two-entry result register and the input register absorb
//   the stall; in_ready drops while a held character's tokens do not fit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "decimal_operator_lexer_defines.svh"

module decimal_operator_lexer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire dol_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output dol_pkg::out_t                    out_data,
  input  wire logic                        cfg_wr_en,
  input  wire logic [dol_pkg::CHAR_W-1:0]  cfg_wr_data
);

  dol_pkg::in_t                 inq;
  logic                         inq_valid;
  logic [dol_pkg::CHAR_W-1:0]   stmt_end;
  dol_pkg::token_res_t          res;
  logic                         room;
  logic                         consume;
  logic                         non_int;
  logic                         non_op;

  assign consume  = inq_valid && room;
  assign in_ready = !inq_valid || consume;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
      stmt_end  <= dol_pkg::STMT_END_RESET;
    end else begin
      if (in_valid && in_ready) begin
        inq_valid <= 1'b1;
      end else if (consume) begin
        inq_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        stmt_end <= cfg_wr_data;
      end
    end
  end

  dol_token_unit u_token (
    .clk      (clk),
    .rst      (rst),
    .fire     (consume),
    .item     (inq),
    .stmt_end (stmt_end),
    .res      (res)
  );

  dol_result_buf u_result (
    .clk       (clk),
    .rst       (rst),
    .push      (consume),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign non_int = out_valid && (out_data.token_kind != dol_pkg::KIND_INTEGER);
  assign non_op  = out_valid && (out_data.token_kind != dol_pkg::KIND_OPERATOR);

  `DOL_ASSERT_IMP(a_own_last, non_int, out_data.last_result, "non-integer token not last")
  `DOL_ASSERT_IMP(a_value_zero, non_int, out_data.integer_value == '0, "value on non-integer")
  `DOL_ASSERT_IMP(a_op_zero, non_op, out_data.operator_char == '0, "char on non-operator")

endmodule

`default_nettype wire

// ===== rtl/core/dol_token_unit.sv =====
// ----------------------------------------------------------------------------
// dol_token_unit
// Classifies one character, keeps the digit-run state and forms up to two
// tokens per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dol_token_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          fire,
  input  wire dol_pkg::in_t                  item,
  input  wire logic [dol_pkg::CHAR_W-1:0]    stmt_end,
  output dol_pkg::token_res_t                res
);

  logic                          pending;
  logic                          pending_next;
  logic [dol_pkg::VALUE_W-1:0]   acc;
  logic [dol_pkg::VALUE_W-1:0]   acc_next;

  logic [dol_pkg::CHAR_W-1:0]    c;
  logic                          eoi;
  logic                          is_dig;
  logic                          is_spc;
  logic                          is_pun;
  logic                          digit_case;
  logic                          flush;
  logic                          has_own;
  logic [3:0]                    d;
  logic [dol_pkg::VALUE_W+3:0]   prod;
  logic [dol_pkg::VALUE_W-1:0]   acc_sat;
  dol_pkg::out_t                 int_tok;
  dol_pkg::out_t                 own_tok;

  always_comb begin
    c      = item.char_code;
    eoi    = item.end_of_input;
    is_dig = (c >= 8'd48) && (c <= 8'd57);
    is_spc = ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
    is_pun = ((c >= 8'd33) && (c <= 8'd47)) || ((c >= 8'd58) && (c <= 8'd64)) ||
             ((c >= 8'd91) && (c <= 8'd96)) || ((c >= 8'd123) && (c <= 8'd126));

    digit_case = !eoi && is_dig;
    flush      = !digit_case && pending;
    has_own    = !eoi && !is_dig && !is_spc;

    d    = c[3:0] - 4'd0;
    prod = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{(dol_pkg::VALUE_W){1'b0}}, d};
    acc_sat = (prod > {4'd0, dol_pkg::VALUE_MAX}) ? dol_pkg::VALUE_MAX
                                                   : prod[dol_pkg::VALUE_W-1:0];

    int_tok.token_kind    = dol_pkg::KIND_INTEGER;
    int_tok.integer_value = acc;
    int_tok.operator_char = '0;
    int_tok.last_result   = !has_own;

    own_tok.integer_value = '0;
    own_tok.operator_char = '0;
    own_tok.last_result   = 1'b1;
    own_tok.token_kind    = dol_pkg::KIND_INVALID;
    if (is_pun) begin
      if (c == stmt_end) begin
        own_tok.token_kind = dol_pkg::KIND_EOS;
      end else begin
        own_tok.token_kind    = dol_pkg::KIND_OPERATOR;
        own_tok.operator_char = c;
      end
    end

    res.n      = {1'b0, flush} + {1'b0, has_own};
    res.first  = flush ? int_tok : own_tok;
    res.second = own_tok;

    pending_next = pending;
    acc_next     = acc;
    if (fire) begin
      if (digit_case) begin
        pending_next = 1'b1;
        acc_next     = pending ? acc_sat : {{(dol_pkg::VALUE_W-4){1'b0}}, d};
      end else begin
        pending_next = 1'b0;
        acc_next     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      acc     <= '0;
    end else begin
      pending <= pending_next;
      acc     <= acc_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dol_result_buf.sv =====
// ----------------------------------------------------------------------------
// dol_result_buf
// Two-entry result register; takes up to two tokens per cycle and hands
// them out one per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "decimal_operator_lexer_defines.svh"

module dol_result_buf (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire dol_pkg::token_res_t  res,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output dol_pkg::out_t             out_data
);

  dol_pkg::out_t slot0;
  dol_pkg::out_t slot0_next;
  dol_pkg::out_t slot1;
  dol_pkg::out_t slot1_next;
  logic [1:0]    count;
  logic [1:0]    count_next;
  logic          pop;
  logic [1:0]    after;

  always_comb begin
    pop   = (count != 2'd0) && out_ready;
    after = count - {1'b0, pop};
    room  = ({1'b0, after} + {1'b0, res.n}) <= 3'd2;

    slot0_next = slot0;
    slot1_next = slot1;
    if (pop) begin
      slot0_next = slot1;
    end
    if (push) begin
      if (after == 2'd0) begin
        slot0_next = res.first;
        slot1_next = res.second;
      end else if (after == 2'd1) begin
        slot1_next = res.first;
      end
    end
    count_next = after + (push ? res.n : 2'd0);
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  assign out_valid = (count != 2'd0);
  assign out_data  = slot0;

  `DOL_ASSERT(a_count_range, count != 2'd3, "result buffer count out of range")
  `DOL_ASSERT_IMP(a_push_fits, push, room, "push without room")
  `DOL_ASSERT_NXT(a_shift, (count == 2'd2) && pop && !push, (count == 2'd1) && (slot0 == $past(slot1)), "second entry not shifted")

endmodule

`default_nettype wire
